// ----- rtl/ses_pkg.sv -----
// shared types, constants and helpers for the scanline edge stepper
package ses_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int IN_W        = 32;
    localparam int DIV_W       = IN_W + 1;
    localparam int DIGIT_W     = 8;
    localparam int BOUND_W     = 16;
    localparam int S_TDATA_W   = 10 * IN_W;
    localparam int M_TDATA_W   = 3 * IN_W + 4 * BOUND_W;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef enum logic
    {
        OP_DIV,
        OP_MUL
    } mdu_op_t;

    typedef struct packed
    {
        logic    start;
        mdu_op_t op;
    } mdu_cmd_t;

    function automatic logic [IN_W-1:0] mag32(input logic signed [IN_W-1:0] a);
        return a[IN_W-1] ? -a : a;
    endfunction

endpackage

// ----- rtl/scanline_edge_stepper_top.sv -----
// scanline edge stepper: top level with sequencer, edge state and output register
// A step word (tuser = 1) advances x, u and v by one scanline: the sums are registered
// in the edge state and copied to the output register in the output state. A load word
// (tuser = 0) first runs the slope division, one quotient bit per cycle (FRAC_BITS + 33
// bits), in the shared multiply/divide unit, unless the edge is flat; then the seven
// fixed-point products for x, u and v go through its 8-bit-digit multiplier in turn.
// s_tready is high only while the sequencer is idle; a finished result waits in the
// output register while the next word is taken.
module scanline_edge_stepper_top #(
    parameter int FRAC_BITS   = ses_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = ses_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // top_x, top_y, bottom_x, bottom_y, u_at_top, u_per_x, u_per_y,
    // v_at_top, v_per_x, v_per_y
    input  logic [ses_pkg::S_TDATA_W-1:0]   s_tdata,
    // func
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // edge_x, tex_u, tex_v, first_row, last_row, first_col, last_col
    output logic [ses_pkg::M_TDATA_W-1:0]   m_tdata,
    // flat_edge
    output logic                            m_tuser
);

    localparam int IN_W  = ses_pkg::IN_W;
    localparam int DIV_W = ses_pkg::DIV_W;
    localparam int BW    = ses_pkg::BOUND_W;
    localparam int VW    = VALUE_WIDTH;
    localparam int XW    = (VW > IN_W) ? VW : IN_W;
    localparam int MW    = XW + 1;
    localparam int SW    = XW + 2;
    localparam int PW    = IN_W + MW;
    localparam int QW    = DIV_W + FRAC_BITS;
    localparam int EW    = ((PW > QW) ? PW : QW) + 1;

    localparam logic signed [VW-1:0] VMAX   = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN   = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [SW-1:0] SAT_HI = SW'(VMAX);
    localparam logic signed [SW-1:0] SAT_LO = SW'(VMIN);
    localparam logic [EW-1:0]        VLIM_E = EW'(1) << (VW - 1);

    localparam logic signed [IN_W:0] CEIL_BIAS = (33'sd1 <<< FRAC_BITS) - 33'sd1;
    localparam logic signed [IN_W:0] BOUND_HI  = 33'sd32767;
    localparam logic signed [IN_W:0] BOUND_LO  = -33'sd32768;
    localparam logic signed [BW-1:0] B_MAX     = 16'sh7fff;
    localparam logic signed [BW-1:0] B_MIN     = 16'sh8000;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MUL_GO,
        S_MUL_WAIT,
        S_MUL_ADD,
        S_OUT
    } state_t;

    typedef enum logic [2:0]
    {
        J_X_PRE,
        J_U_X,
        J_U_Y,
        J_U_STEP,
        J_V_X,
        J_V_Y,
        J_V_STEP
    } job_t;

    function automatic logic signed [BW-1:0] ceil_bound(input logic signed [IN_W-1:0] v);
        logic signed [IN_W:0] n;
        logic signed [IN_W:0] c;
        n = (IN_W+1)'(v) + CEIL_BIAS;
        c = n >>> FRAC_BITS;
        if (c > BOUND_HI)
            return B_MAX;
        else if (c < BOUND_LO)
            return B_MIN;
        else
            return c[BW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] sat_v(input logic signed [SW-1:0] s);
        if (s > SAT_HI)
            return VMAX;
        else if (s < SAT_LO)
            return VMIN;
        else
            return s[VW-1:0];
    endfunction

    // input word fields
    logic signed [IN_W-1:0] in_top_x, in_top_y, in_bottom_x, in_bottom_y;
    logic signed [IN_W-1:0] in_u_at_top, in_u_per_x, in_u_per_y;
    logic signed [IN_W-1:0] in_v_at_top, in_v_per_x, in_v_per_y;

    assign in_top_x    = s_tdata[0*IN_W +: IN_W];
    assign in_top_y    = s_tdata[1*IN_W +: IN_W];
    assign in_bottom_x = s_tdata[2*IN_W +: IN_W];
    assign in_bottom_y = s_tdata[3*IN_W +: IN_W];
    assign in_u_at_top = s_tdata[4*IN_W +: IN_W];
    assign in_u_per_x  = s_tdata[5*IN_W +: IN_W];
    assign in_u_per_y  = s_tdata[6*IN_W +: IN_W];
    assign in_v_at_top = s_tdata[7*IN_W +: IN_W];
    assign in_v_per_x  = s_tdata[8*IN_W +: IN_W];
    assign in_v_per_y  = s_tdata[9*IN_W +: IN_W];

    // control and edge state
    state_t                 state_reg, state_next;
    job_t                   job_reg, job_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic signed [VW-1:0]   cur_x_reg, cur_x_next;
    logic signed [VW-1:0]   slope_reg, slope_next;
    logic signed [VW-1:0]   cur_u_reg, cur_u_next;
    logic signed [VW-1:0]   u_step_reg, u_step_next;
    logic signed [VW-1:0]   cur_v_reg, cur_v_next;
    logic signed [VW-1:0]   v_step_reg, v_step_next;
    logic signed [BW-1:0]   first_row_reg, first_row_next;
    logic signed [BW-1:0]   last_row_reg, last_row_next;
    logic signed [BW-1:0]   first_col_reg, first_col_next;
    logic signed [BW-1:0]   last_col_reg, last_col_next;
    logic                   flat_reg, flat_next;

    // operands and working values
    logic signed [IN_W-1:0] tx_reg, tx_next;
    logic signed [IN_W-1:0] u0_reg, u0_next;
    logic signed [IN_W-1:0] upx_reg, upx_next;
    logic signed [IN_W-1:0] upy_reg, upy_next;
    logic signed [IN_W-1:0] v0_reg, v0_next;
    logic signed [IN_W-1:0] vpx_reg, vpx_next;
    logic signed [IN_W-1:0] vpy_reg, vpy_next;
    logic [FRAC_BITS-1:0]   pre_reg, pre_next;
    logic signed [DIV_W-1:0] dx_reg, dx_next;
    logic signed [DIV_W-1:0] dy_reg, dy_next;
    logic                   neg_reg, neg_next;
    logic signed [VW-1:0]   t_reg, t_next;
    logic signed [VW-1:0]   m_reg, m_next;

    // output word
    logic [IN_W-1:0]        edge_x_reg, edge_x_next;
    logic [IN_W-1:0]        tex_u_reg, tex_u_next;
    logic [IN_W-1:0]        tex_v_reg, tex_v_next;
    logic [BW-1:0]          o_first_row_reg, o_first_row_next;
    logic [BW-1:0]          o_last_row_reg, o_last_row_next;
    logic [BW-1:0]          o_first_col_reg, o_first_col_next;
    logic [BW-1:0]          o_last_col_reg, o_last_col_next;
    logic                   o_flat_reg, o_flat_next;

    // shared unit
    ses_pkg::mdu_cmd_t      mdu_cmd;
    logic [MW-1:0]          mdu_opa;
    logic [DIV_W-1:0]       mdu_opb;
    logic                   mdu_done;
    logic [PW-1:0]          mdu_prod;
    logic [QW-1:0]          mdu_quo;

    // datapath helpers
    logic signed [DIV_W-1:0] in_dx, in_dy;
    logic [VW-1:0]          slope_mag;
    logic signed [MW-1:0]   xpre;
    logic [MW-1:0]          xpre_mag;
    logic [DIV_W-1:0]       dx_mag, dy_mag;
    logic [PW-1:0]          q_mul;
    logic [EW-1:0]          q_mul_e, q_div_e;
    logic                   rem_nz;
    logic signed [VW-1:0]   mul_val, div_val;
    logic signed [SW-1:0]   add_a, add_b, add_sum;
    logic signed [XW-1:0]   cur_x_w, cur_u_w, cur_v_w;

    assign in_dx     = DIV_W'(in_bottom_x) - DIV_W'(in_top_x);
    assign in_dy     = DIV_W'(in_bottom_y) - DIV_W'(in_top_y);
    assign slope_mag = slope_reg[VW-1] ? -slope_reg : slope_reg;
    assign xpre      = MW'(cur_x_reg) - MW'(tx_reg);
    assign xpre_mag  = xpre[MW-1] ? -xpre : xpre;
    assign dx_mag    = dx_reg[DIV_W-1] ? -dx_reg : dx_reg;
    assign dy_mag    = dy_reg[DIV_W-1] ? -dy_reg : dy_reg;

    // product post-processing: floor shift and saturate
    assign q_mul   = mdu_prod >> FRAC_BITS;
    assign q_mul_e = EW'(q_mul);
    assign rem_nz  = |mdu_prod[FRAC_BITS-1:0];
    always_comb
    begin
        if (q_mul_e >= VLIM_E)
            mul_val = neg_reg ? VMIN : VMAX;
        else if (neg_reg)
            mul_val = -(q_mul[VW-1:0] + VW'(rem_nz));
        else
            mul_val = q_mul[VW-1:0];
    end

    // quotient saturate, truncated toward zero
    assign q_div_e = EW'(mdu_quo);
    always_comb
    begin
        if (q_div_e >= VLIM_E)
            div_val = neg_reg ? VMIN : VMAX;
        else if (neg_reg)
            div_val = -q_div_e[VW-1:0];
        else
            div_val = q_div_e[VW-1:0];
    end

    // commit adder operands per job
    always_comb
    begin
        case (job_reg)
            J_X_PRE:
            begin
                add_a = SW'(tx_reg);
                add_b = '0;
            end
            J_U_Y:
            begin
                add_a = SW'(u0_reg);
                add_b = SW'(t_reg);
            end
            J_U_STEP:
            begin
                add_a = SW'(upy_reg);
                add_b = '0;
            end
            J_V_Y:
            begin
                add_a = SW'(v0_reg);
                add_b = SW'(t_reg);
            end
            J_V_STEP:
            begin
                add_a = SW'(vpy_reg);
                add_b = '0;
            end
            default:
            begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end
    assign add_sum = add_a + add_b + SW'(m_reg);

    // shared unit command and operands
    always_comb
    begin
        mdu_cmd.start = (state_reg == S_DIV_GO) || (state_reg == S_MUL_GO);
        mdu_cmd.op    = (state_reg == S_DIV_GO) ? ses_pkg::OP_DIV : ses_pkg::OP_MUL;
        if (state_reg == S_DIV_GO)
        begin
            mdu_opa = MW'(dx_mag);
            mdu_opb = dy_mag;
        end
        else
        begin
            case (job_reg)
                J_X_PRE:
                begin
                    mdu_opa = MW'(slope_mag);
                    mdu_opb = DIV_W'(pre_reg);
                end
                J_U_X:
                begin
                    mdu_opa = xpre_mag;
                    mdu_opb = DIV_W'(ses_pkg::mag32(upx_reg));
                end
                J_U_Y:
                begin
                    mdu_opa = MW'(pre_reg);
                    mdu_opb = DIV_W'(ses_pkg::mag32(upy_reg));
                end
                J_U_STEP:
                begin
                    mdu_opa = MW'(slope_mag);
                    mdu_opb = DIV_W'(ses_pkg::mag32(upx_reg));
                end
                J_V_X:
                begin
                    mdu_opa = xpre_mag;
                    mdu_opb = DIV_W'(ses_pkg::mag32(vpx_reg));
                end
                J_V_Y:
                begin
                    mdu_opa = MW'(pre_reg);
                    mdu_opb = DIV_W'(ses_pkg::mag32(vpy_reg));
                end
                J_V_STEP:
                begin
                    mdu_opa = MW'(slope_mag);
                    mdu_opb = DIV_W'(ses_pkg::mag32(vpx_reg));
                end
                default:
                begin
                    mdu_opa = '0;
                    mdu_opb = '0;
                end
            endcase
        end
    end

    ses_mdu #(
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mdu_cmd),
        .opa   (mdu_opa),
        .opb   (mdu_opb),
        .done  (mdu_done),
        .prod  (mdu_prod),
        .quo   (mdu_quo)
    );

    assign cur_x_w = XW'(cur_x_reg);
    assign cur_u_w = XW'(cur_u_reg);
    assign cur_v_w = XW'(cur_v_reg);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        job_next         = job_reg;
        m_tvalid_next    = m_tvalid_reg & ~m_tready;
        cur_x_next       = cur_x_reg;
        slope_next       = slope_reg;
        cur_u_next       = cur_u_reg;
        u_step_next      = u_step_reg;
        cur_v_next       = cur_v_reg;
        v_step_next      = v_step_reg;
        first_row_next   = first_row_reg;
        last_row_next    = last_row_reg;
        first_col_next   = first_col_reg;
        last_col_next    = last_col_reg;
        flat_next        = flat_reg;
        tx_next          = tx_reg;
        u0_next          = u0_reg;
        upx_next         = upx_reg;
        upy_next         = upy_reg;
        v0_next          = v0_reg;
        vpx_next         = vpx_reg;
        vpy_next         = vpy_reg;
        pre_next         = pre_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        neg_next         = neg_reg;
        t_next           = t_reg;
        m_next           = m_reg;
        edge_x_next      = edge_x_reg;
        tex_u_next       = tex_u_reg;
        tex_v_next       = tex_v_reg;
        o_first_row_next = o_first_row_reg;
        o_last_row_next  = o_last_row_reg;
        o_first_col_next = o_first_col_reg;
        o_last_col_next  = o_last_col_reg;
        o_flat_next      = o_flat_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == ses_pkg::FUNC_STEP)
                    begin
                        cur_x_next = sat_v(SW'(cur_x_reg) + SW'(slope_reg));
                        cur_u_next = sat_v(SW'(cur_u_reg) + SW'(u_step_reg));
                        cur_v_next = sat_v(SW'(cur_v_reg) + SW'(v_step_reg));
                        state_next = S_OUT;
                    end
                    else
                    begin
                        tx_next        = in_top_x;
                        u0_next        = in_u_at_top;
                        upx_next       = in_u_per_x;
                        upy_next       = in_u_per_y;
                        v0_next        = in_v_at_top;
                        vpx_next       = in_v_per_x;
                        vpy_next       = in_v_per_y;
                        pre_next       = FRAC_BITS'(-in_top_y);
                        dx_next        = in_dx;
                        dy_next        = in_dy;
                        first_row_next = ceil_bound(in_top_y);
                        last_row_next  = ceil_bound(in_bottom_y);
                        first_col_next = ceil_bound(in_top_x);
                        last_col_next  = ceil_bound(in_bottom_x);
                        job_next       = J_X_PRE;
                        if (in_dy == '0)
                        begin
                            slope_next = '0;
                            flat_next  = 1'b1;
                            state_next = S_MUL_GO;
                        end
                        else
                        begin
                            flat_next  = 1'b0;
                            state_next = S_DIV_GO;
                        end
                    end
                end
            end
            S_DIV_GO:
            begin
                neg_next   = dx_reg[DIV_W-1] ^ dy_reg[DIV_W-1];
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (mdu_done)
                begin
                    slope_next = div_val;
                    state_next = S_MUL_GO;
                end
            end
            S_MUL_GO:
            begin
                case (job_reg)
                    J_X_PRE:  neg_next = slope_reg[VW-1];
                    J_U_X:    neg_next = upx_reg[IN_W-1] ^ xpre[MW-1];
                    J_U_Y:    neg_next = upy_reg[IN_W-1];
                    J_U_STEP: neg_next = upx_reg[IN_W-1] ^ slope_reg[VW-1];
                    J_V_X:    neg_next = vpx_reg[IN_W-1] ^ xpre[MW-1];
                    J_V_Y:    neg_next = vpy_reg[IN_W-1];
                    J_V_STEP: neg_next = vpx_reg[IN_W-1] ^ slope_reg[VW-1];
                    default:  neg_next = 1'b0;
                endcase
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (mdu_done)
                begin
                    m_next     = mul_val;
                    state_next = S_MUL_ADD;
                end
            end
            S_MUL_ADD:
            begin
                case (job_reg)
                    J_X_PRE:  cur_x_next  = sat_v(add_sum);
                    J_U_X:    t_next      = m_reg;
                    J_U_Y:    cur_u_next  = sat_v(add_sum);
                    J_U_STEP: u_step_next = sat_v(add_sum);
                    J_V_X:    t_next      = m_reg;
                    J_V_Y:    cur_v_next  = sat_v(add_sum);
                    J_V_STEP: v_step_next = sat_v(add_sum);
                    default:  t_next      = t_reg;
                endcase
                if (job_reg == J_V_STEP)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    job_next   = job_t'(job_reg + 3'd1);
                    state_next = S_MUL_GO;
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    edge_x_next      = cur_x_w[IN_W-1:0];
                    tex_u_next       = cur_u_w[IN_W-1:0];
                    tex_v_next       = cur_v_w[IN_W-1:0];
                    o_first_row_next = first_row_reg;
                    o_last_row_next  = last_row_reg;
                    o_first_col_next = first_col_reg;
                    o_last_col_next  = last_col_reg;
                    o_flat_next      = flat_reg;
                    m_tvalid_next    = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= J_X_PRE;
            m_tvalid_reg  <= 1'b0;
            cur_x_reg     <= '0;
            slope_reg     <= '0;
            cur_u_reg     <= '0;
            u_step_reg    <= '0;
            cur_v_reg     <= '0;
            v_step_reg    <= '0;
            first_row_reg <= '0;
            last_row_reg  <= '0;
            first_col_reg <= '0;
            last_col_reg  <= '0;
            flat_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            m_tvalid_reg  <= m_tvalid_next;
            cur_x_reg     <= cur_x_next;
            slope_reg     <= slope_next;
            cur_u_reg     <= cur_u_next;
            u_step_reg    <= u_step_next;
            cur_v_reg     <= cur_v_next;
            v_step_reg    <= v_step_next;
            first_row_reg <= first_row_next;
            last_row_reg  <= last_row_next;
            first_col_reg <= first_col_next;
            last_col_reg  <= last_col_next;
            flat_reg      <= flat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_reg          <= tx_next;
        u0_reg          <= u0_next;
        upx_reg         <= upx_next;
        upy_reg         <= upy_next;
        v0_reg          <= v0_next;
        vpx_reg         <= vpx_next;
        vpy_reg         <= vpy_next;
        pre_reg         <= pre_next;
        dx_reg          <= dx_next;
        dy_reg          <= dy_next;
        neg_reg         <= neg_next;
        t_reg           <= t_next;
        m_reg           <= m_next;
        edge_x_reg      <= edge_x_next;
        tex_u_reg       <= tex_u_next;
        tex_v_reg       <= tex_v_next;
        o_first_row_reg <= o_first_row_next;
        o_last_row_reg  <= o_last_row_next;
        o_first_col_reg <= o_first_col_next;
        o_last_col_reg  <= o_last_col_next;
        o_flat_reg      <= o_flat_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {o_last_col_reg, o_first_col_reg, o_last_row_reg, o_first_row_reg,
                       tex_v_reg, tex_u_reg, edge_x_reg};
    assign m_tuser  = o_flat_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mdu_done |-> (state_reg == S_DIV_WAIT || state_reg == S_MUL_WAIT))
        else $error("shared unit finished outside a wait state");

    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_OUT)
        else $error("output word raised outside the output state");

    a_flat_slope: assert property (@(posedge clk) disable iff (!rst_n)
        flat_reg |-> slope_reg == '0)
        else $error("flat edge with nonzero slope");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg != S_IDLE)
        else $error("accepted word did not start work");

endmodule

// ----- rtl/ses_mdu.sv -----
// shared multiply / divide unit: bit-serial divider and digit-serial multiplier
module ses_mdu #(
    parameter int FRAC_BITS   = ses_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = ses_pkg::VALUE_WIDTH_DEF,
    localparam int WIDE_W = ((VALUE_WIDTH > ses_pkg::IN_W) ? VALUE_WIDTH : ses_pkg::IN_W) + 1,
    localparam int PROD_W = ses_pkg::IN_W + WIDE_W,
    localparam int QUO_W  = ses_pkg::DIV_W + FRAC_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ses_pkg::mdu_cmd_t          cmd,
    input  logic [WIDE_W-1:0]          opa,
    input  logic [ses_pkg::DIV_W-1:0]  opb,
    output logic                       done,
    output logic [PROD_W-1:0]          prod,
    output logic [QUO_W-1:0]           quo
);

    localparam int DIV_W     = ses_pkg::DIV_W;
    localparam int IN_W      = ses_pkg::IN_W;
    localparam int DIGIT_W   = ses_pkg::DIGIT_W;
    localparam int PP_W      = DIGIT_W + WIDE_W;
    localparam int MUL_STEPS = IN_W / DIGIT_W;
    localparam int CNT_W     = $clog2(QUO_W + 1);

    logic                busy_reg, busy_next;
    ses_pkg::mdu_op_t    op_reg, op_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [WIDE_W-1:0]   opa_reg, opa_next;
    logic [DIV_W-1:0]    opb_reg, opb_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;

    logic [DIGIT_W-1:0]  digit;
    logic [PP_W-1:0]     pp;
    logic [DIV_W:0]      trial;
    logic [DIV_W:0]      diff;
    logic                fits;

    assign digit = opb_reg[IN_W-1 -: DIGIT_W];
    assign pp    = PP_W'(digit) * PP_W'(opa_reg);
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, opb_reg};
    assign fits  = (trial >= {1'b0, opb_reg});

    always_comb
    begin
        busy_next = busy_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            opa_next  = opa;
            opb_next  = opb;
            acc_next  = '0;
            rem_next  = '0;
            quo_next  = {opa[DIV_W-1:0], {FRAC_BITS{1'b0}}};
            cnt_next  = (cmd.op == ses_pkg::OP_DIV) ? CNT_W'(QUO_W) : CNT_W'(MUL_STEPS);
        end
        else if (busy_reg)
        begin
            case (op_reg)
                ses_pkg::OP_MUL:
                begin
                    acc_next = (acc_reg << DIGIT_W) + PROD_W'(pp);
                    opb_next = {opb_reg[DIV_W-1:IN_W], opb_reg[IN_W-1:0] << DIGIT_W};
                end
                ses_pkg::OP_DIV:
                begin
                    if (fits)
                    begin
                        rem_next = diff[DIV_W-1:0];
                        quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial[DIV_W-1:0];
                        quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                    end
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            op_reg   <= ses_pkg::OP_DIV;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
    assign quo  = quo_reg;

endmodule
